// ===== rtl/mark_sweep_cell_heap_top_assert.svh =====
// ---------------------------------------------------------------------------
// Mark-sweep cell heap assertion macros
// Shared property wrappers for the port checker.
// ---------------------------------------------------------------------------
`ifndef MARK_SWEEP_CELL_HEAP_TOP_ASSERT_SVH
`define MARK_SWEEP_CELL_HEAP_TOP_ASSERT_SVH

// clocked property, disabled during reset
`define MSCH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("msch port check failed");

// condition that must never hold
`define MSCH_NEVER(lbl, cond) \
  `MSCH_ASSERT(lbl, !(cond))

`endif

// ===== rtl/msch_pkg.sv =====
// ---------------------------------------------------------------------------
// Mark-sweep cell heap package
// Sizes, codes and controller/datapath command and status types.
// ---------------------------------------------------------------------------
package msch_pkg;

  localparam int unsigned HEAP_CELLS  = 1024;
  localparam int unsigned ROOT_SLOTS  = 256;
  localparam int unsigned STACK_DEPTH = 1024;

  localparam int unsigned HEAP_AW = $clog2(HEAP_CELLS);
  localparam int unsigned CUR_W   = $clog2(HEAP_CELLS + 1);
  localparam int unsigned ROOT_AW = $clog2(ROOT_SLOTS);
  localparam int unsigned ROOT_CW = $clog2(ROOT_SLOTS + 1);
  localparam int unsigned STK_AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SP_W    = $clog2(STACK_DEPTH + 1);

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned TAG_W   = 3;
  localparam int unsigned LINK_W  = 11;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FSEL_W  = 2;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned FREED_W = 11;
  localparam int unsigned ROOTS_W = 9;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SET     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_COLLECT = 3'd6;

  localparam logic [TAG_W-1:0] TAG_CONS    = 3'd2;
  localparam logic [TAG_W-1:0] TAG_CLOSURE = 3'd3;
  localparam logic [TAG_W-1:0] TAG_UMACRO  = 3'd4;
  localparam logic [TAG_W-1:0] TAG_UNUSED  = 3'd7;

  localparam logic [FSEL_W-1:0] FSEL_FIRST  = 2'd0;
  localparam logic [FSEL_W-1:0] FSEL_SECOND = 2'd1;
  localparam logic [FSEL_W-1:0] FSEL_THIRD  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_OOM       = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd2;
  localparam logic [STAT_W-1:0] ST_ROOTS     = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLEAR,
    OP_READ_CELL,
    OP_READ_DONE,
    OP_WRITE_FIELD,
    OP_PUSH_ROOT,
    OP_POP_ROOT,
    OP_POP_DONE,
    OP_SET_ROOT,
    OP_SCAN_RD,
    OP_SCAN_NEXT,
    OP_ALLOC,
    OP_GC_START,
    OP_ROOT_RD,
    OP_ROOT_PUSH,
    OP_ROOT_NEXT,
    OP_STK_POP,
    OP_CELL_RD,
    OP_MARK,
    OP_PUSH_B,
    OP_PUSH_C,
    OP_SWEEP_START,
    OP_UNMARK,
    OP_SWEEP_RD,
    OP_SWEEP_WR,
    OP_GC_DONE,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e              op;
    logic                in_ready;
    logic [STAT_W-1:0]   status;
  } ctrl_t;

  typedef struct packed {
    logic                in_fire;
    logic [CMD_W-1:0]    cmd;
    logic                cfg_gc;
    logic                ctype_unused;
    logic                tgt_oob;
    logic                roots_full;
    logic                roots_empty;
    logic                set_bad;
    logic                cursor_end;
    logic                tag_free;
    logic                root_done;
    logic                stack_empty;
    logic                v_oob;
    logic                skip_cell;
    logic                follow2;
    logic                follow3;
    logic                sweep_last;
    logic                over;
    logic                freed_zero;
    logic                out_free;
  } dp_stat_t;

endpackage

// ===== rtl/msch_if.sv =====
// ---------------------------------------------------------------------------
// Mark-sweep cell heap channels
// Command, result and configuration channels with valid/ready.
// ---------------------------------------------------------------------------
interface msch_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [2:0]         cell_type;
  logic [10:0]        first_link;
  logic [10:0]        second_link;
  logic [10:0]        third_link;
  logic signed [31:0] data_word;
  logic [10:0]        target_index;
  logic [1:0]         field_select;

  modport source (output valid, command, cell_type, first_link, second_link, third_link,
                  data_word, target_index, field_select, input ready);
  modport sink   (input valid, command, cell_type, first_link, second_link, third_link,
                  data_word, target_index, field_select, output ready);
endinterface

interface msch_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [10:0]        cell_index;
  logic [2:0]         cell_kind;
  logic [10:0]        link_a;
  logic [10:0]        link_b;
  logic [10:0]        link_c;
  logic signed [31:0] payload;
  logic [10:0]        freed_count;
  logic [8:0]         roots_in_use;

  modport source (output valid, status, cell_index, cell_kind, link_a, link_b, link_c,
                  payload, freed_count, roots_in_use, input ready);
  modport sink   (input valid, status, cell_index, cell_kind, link_a, link_b, link_c,
                  payload, freed_count, roots_in_use, output ready);
endinterface

interface msch_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/mark_sweep_cell_heap_top.sv =====
// ---------------------------------------------------------------------------
// Mark-sweep cell heap
// Cell heap with next-fit allocation and a mark and sweep collector.
// ---------------------------------------------------------------------------
// One command is handled at a time, each giving one result. Allocation
// steps the cursor over occupied cells to the next free one. A collection
// reads each root, pops and marks mark stack entries, and sweeps every heap
// cell (on a mark stack overflow the sweep only clears the marks). After
// reset a clearing pass over all HEAP_CELLS cells (1024) runs before the
// first command is accepted.
module mark_sweep_cell_heap_top import msch_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  msch_cfg_if.sink   cfg_i,
  msch_in_if.sink    in_i,
  msch_out_if.source out_o
);

  ctrl_t    ctrl;
  dp_stat_t stat;

  msch_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  msch_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .cfg_i  (cfg_i),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

// ===== rtl/msch_dp.sv =====
// ---------------------------------------------------------------------------
// Mark-sweep cell heap datapath
// Cell, root and mark stack memories, cursors, counters and result register.
// ---------------------------------------------------------------------------
module msch_dp import msch_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctrl_i,
  output dp_stat_t    stat_o,
  msch_cfg_if.sink    cfg_i,
  msch_in_if.sink     in_i,
  msch_out_if.source  out_o
);

  logic [TAG_W-1:0]  tag_mem  [HEAP_CELLS];
  logic              mark_mem [HEAP_CELLS];
  logic [LINK_W-1:0] fl_mem   [HEAP_CELLS];
  logic [LINK_W-1:0] sl_mem   [HEAP_CELLS];
  logic [LINK_W-1:0] tl_mem   [HEAP_CELLS];
  logic [DATA_W-1:0] pay_mem  [HEAP_CELLS];
  logic [LINK_W-1:0] root_mem [ROOT_SLOTS];
  logic [LINK_W-1:0] stk_mem  [STACK_DEPTH];

  logic [TAG_W-1:0]  tag_rd_q;
  logic              mark_rd_q;
  logic [LINK_W-1:0] fl_rd_q, sl_rd_q, tl_rd_q, root_rd_q, stk_rd_q;
  logic [DATA_W-1:0] pay_rd_q;

  logic               cell_re, tag_we, mark_we, fl_we, sl_we, tl_we, pay_we;
  logic [HEAP_AW-1:0] cell_raddr, cell_waddr;
  logic [TAG_W-1:0]   tag_wd;
  logic               mark_wd;
  logic [LINK_W-1:0]  fl_wd, sl_wd, tl_wd;
  logic [DATA_W-1:0]  pay_wd;
  logic               root_re, root_we;
  logic [ROOT_AW-1:0] root_raddr, root_waddr;
  logic [LINK_W-1:0]  root_wd;
  logic               stk_re, stk_we;
  logic [STK_AW-1:0]  stk_raddr, stk_waddr;
  logic [LINK_W-1:0]  stk_wd;
  logic               push_en;
  logic [LINK_W-1:0]  push_val;

  logic                cfg_gc_q;
  logic [CMD_W-1:0]    cmd_q;
  logic [TAG_W-1:0]    ctype_q;
  logic [LINK_W-1:0]   la_q, lb_q, lc_q, tgt_q;
  logic [DATA_W-1:0]   dw_q;
  logic [FSEL_W-1:0]   fsel_q;

  logic [CUR_W-1:0]    cursor_q, cursor_d, i_q, i_d, freed_q, freed_d, lf_q, lf_d;
  logic [ROOT_CW-1:0]  cnt_q, cnt_d, r_q, r_d;
  logic [SP_W-1:0]     sp_q, sp_d;
  logic                over_q, over_d;
  logic [HEAP_AW-1:0]  v_q, v_d;
  logic [LINK_W-1:0]   p_idx_q, p_idx_d, p_a_q, p_a_d, p_b_q, p_b_d, p_c_q, p_c_d;
  logic [TAG_W-1:0]    p_kind_q, p_kind_d;
  logic [DATA_W-1:0]   p_pay_q, p_pay_d;
  logic                out_valid_q, out_valid_d;
  logic                in_fire;
  logic                ok;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = ctrl_i.in_ready;
  assign in_fire     = in_i.valid & ctrl_i.in_ready;
  assign ok          = (ctrl_i.status == ST_OK);

  always_comb begin
    cell_re    = 1'b0;
    cell_raddr = '0;
    cell_waddr = '0;
    tag_we = 1'b0; mark_we = 1'b0; fl_we = 1'b0; sl_we = 1'b0; tl_we = 1'b0; pay_we = 1'b0;
    tag_wd = TAG_UNUSED; mark_wd = 1'b0;
    fl_wd = '0; sl_wd = '0; tl_wd = '0; pay_wd = '0;
    root_re = 1'b0; root_we = 1'b0; root_raddr = '0; root_waddr = '0; root_wd = la_q;
    stk_re = 1'b0; stk_we = 1'b0; stk_raddr = '0; stk_waddr = '0; stk_wd = '0;
    push_en = 1'b0; push_val = '0;
    cursor_d = cursor_q; i_d = i_q; freed_d = freed_q; lf_d = lf_q;
    cnt_d = cnt_q; r_d = r_q; sp_d = sp_q; over_d = over_q; v_d = v_q;
    p_idx_d = p_idx_q; p_kind_d = p_kind_q; p_a_d = p_a_q; p_b_d = p_b_q;
    p_c_d = p_c_q; p_pay_d = p_pay_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    if (in_fire) begin
      p_idx_d = '0; p_kind_d = '0; p_a_d = '0; p_b_d = '0; p_c_d = '0; p_pay_d = '0;
    end
    unique case (ctrl_i.op)
      OP_CLEAR: begin
        cell_waddr = HEAP_AW'(i_q);
        tag_we = 1'b1; mark_we = 1'b1;
        i_d = i_q + 1'b1;
      end
      OP_READ_CELL: begin
        cell_re = 1'b1; cell_raddr = HEAP_AW'(tgt_q);
      end
      OP_READ_DONE: begin
        p_idx_d = tgt_q; p_kind_d = tag_rd_q; p_a_d = fl_rd_q; p_b_d = sl_rd_q;
        p_c_d = tl_rd_q; p_pay_d = pay_rd_q;
      end
      OP_WRITE_FIELD: begin
        cell_waddr = HEAP_AW'(tgt_q);
        fl_wd = dw_q[LINK_W-1:0]; sl_wd = dw_q[LINK_W-1:0]; tl_wd = dw_q[LINK_W-1:0];
        pay_wd = dw_q;
        unique case (fsel_q)
          FSEL_FIRST:  fl_we = 1'b1;
          FSEL_SECOND: sl_we = 1'b1;
          FSEL_THIRD:  tl_we = 1'b1;
          default:     pay_we = 1'b1;
        endcase
        p_idx_d = tgt_q;
      end
      OP_PUSH_ROOT: begin
        root_we = 1'b1; root_waddr = ROOT_AW'(cnt_q);
        cnt_d = cnt_q + 1'b1;
        p_idx_d = la_q;
      end
      OP_POP_ROOT: begin
        root_re = 1'b1; root_raddr = ROOT_AW'(cnt_q - 1'b1);
        cnt_d = cnt_q - 1'b1;
      end
      OP_POP_DONE: p_idx_d = root_rd_q;
      OP_SET_ROOT: begin
        root_we = 1'b1; root_waddr = ROOT_AW'(tgt_q);
        p_idx_d = la_q;
      end
      OP_SCAN_RD: begin
        cell_re = 1'b1; cell_raddr = HEAP_AW'(cursor_q);
      end
      OP_SCAN_NEXT: cursor_d = cursor_q + 1'b1;
      OP_ALLOC: begin
        cell_waddr = HEAP_AW'(cursor_q);
        tag_we = 1'b1; mark_we = 1'b1; fl_we = 1'b1; sl_we = 1'b1; tl_we = 1'b1;
        pay_we = 1'b1;
        tag_wd = ctype_q; fl_wd = la_q; sl_wd = lb_q; tl_wd = lc_q; pay_wd = dw_q;
        p_idx_d = LINK_W'(cursor_q);
        cursor_d = cursor_q + 1'b1;
      end
      OP_GC_START: begin
        over_d = 1'b0; r_d = '0;
      end
      OP_ROOT_RD: begin
        root_re = 1'b1; root_raddr = ROOT_AW'(r_q);
        sp_d = '0;
      end
      OP_ROOT_PUSH: begin
        stk_we = 1'b1; stk_waddr = '0; stk_wd = root_rd_q;
        sp_d = SP_W'(1);
      end
      OP_ROOT_NEXT: r_d = r_q + 1'b1;
      OP_STK_POP: begin
        stk_re = 1'b1; stk_raddr = STK_AW'(sp_q - 1'b1);
        sp_d = sp_q - 1'b1;
      end
      OP_CELL_RD: begin
        cell_re = 1'b1; cell_raddr = HEAP_AW'(stk_rd_q);
        v_d = HEAP_AW'(stk_rd_q);
      end
      OP_MARK: begin
        cell_waddr = v_q; mark_we = 1'b1; mark_wd = 1'b1;
        push_en = stat_o.follow2 | stat_o.follow3; push_val = fl_rd_q;
      end
      OP_PUSH_B: begin
        push_en = 1'b1; push_val = sl_rd_q;
      end
      OP_PUSH_C: begin
        push_en = 1'b1; push_val = tl_rd_q;
      end
      OP_SWEEP_START: begin
        i_d = '0; freed_d = '0;
      end
      OP_UNMARK: begin
        cell_waddr = HEAP_AW'(i_q); mark_we = 1'b1;
        i_d = i_q + 1'b1;
      end
      OP_SWEEP_RD: begin
        cell_re = 1'b1; cell_raddr = HEAP_AW'(i_q);
      end
      OP_SWEEP_WR: begin
        cell_waddr = HEAP_AW'(i_q);
        mark_we = 1'b1;
        if (!mark_rd_q) begin
          tag_we = 1'b1; fl_we = 1'b1; sl_we = 1'b1; tl_we = 1'b1; pay_we = 1'b1;
          freed_d = freed_q + 1'b1;
        end
        i_d = i_q + 1'b1;
      end
      OP_GC_DONE: begin
        if (over_q) begin
          lf_d = '0;
        end else begin
          lf_d = freed_q; cursor_d = '0;
        end
      end
      OP_FINISH: out_valid_d = 1'b1;
      default: ;
    endcase
    if (push_en) begin
      if (32'(sp_q) >= STACK_DEPTH) begin
        over_d = 1'b1;
      end else begin
        stk_we = 1'b1; stk_waddr = STK_AW'(sp_q); stk_wd = push_val;
        sp_d = sp_q + 1'b1;
      end
    end
  end

  always_comb begin
    stat_o.in_fire      = in_fire;
    stat_o.cmd          = cmd_q;
    stat_o.cfg_gc       = cfg_gc_q;
    stat_o.ctype_unused = (ctype_q == TAG_UNUSED);
    stat_o.tgt_oob      = (32'(tgt_q) >= HEAP_CELLS);
    stat_o.roots_full   = (32'(cnt_q) >= ROOT_SLOTS);
    stat_o.roots_empty  = (cnt_q == '0);
    stat_o.set_bad      = (32'(tgt_q) >= 32'(cnt_q));
    stat_o.cursor_end   = (32'(cursor_q) >= HEAP_CELLS);
    stat_o.tag_free     = (tag_rd_q == TAG_UNUSED);
    stat_o.root_done    = (r_q >= cnt_q) | over_q;
    stat_o.stack_empty  = (sp_q == '0) | over_q;
    stat_o.v_oob        = (32'(stk_rd_q) >= HEAP_CELLS);
    stat_o.skip_cell    = mark_rd_q | (tag_rd_q == TAG_UNUSED);
    stat_o.follow2      = (tag_rd_q == TAG_CONS);
    stat_o.follow3      = (tag_rd_q == TAG_CLOSURE) | (tag_rd_q == TAG_UMACRO);
    stat_o.sweep_last   = (32'(i_q) == HEAP_CELLS - 1);
    stat_o.over         = over_q;
    stat_o.freed_zero   = (freed_q == '0);
    stat_o.out_free     = ~out_valid_q | out_o.ready;
  end

  always_ff @(posedge clk_i) begin
    if (tag_we)  tag_mem[cell_waddr]  <= tag_wd;
    if (mark_we) mark_mem[cell_waddr] <= mark_wd;
    if (fl_we)   fl_mem[cell_waddr]   <= fl_wd;
    if (sl_we)   sl_mem[cell_waddr]   <= sl_wd;
    if (tl_we)   tl_mem[cell_waddr]   <= tl_wd;
    if (pay_we)  pay_mem[cell_waddr]  <= pay_wd;
    if (cell_re) begin
      tag_rd_q  <= tag_mem[cell_raddr];
      mark_rd_q <= mark_mem[cell_raddr];
      fl_rd_q   <= fl_mem[cell_raddr];
      sl_rd_q   <= sl_mem[cell_raddr];
      tl_rd_q   <= tl_mem[cell_raddr];
      pay_rd_q  <= pay_mem[cell_raddr];
    end
    if (root_we) root_mem[root_waddr] <= root_wd;
    if (root_re) root_rd_q <= root_mem[root_raddr];
    if (stk_we)  stk_mem[stk_waddr] <= stk_wd;
    if (stk_re)  stk_rd_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= in_i.command;
      ctype_q <= in_i.cell_type;
      la_q    <= in_i.first_link;
      lb_q    <= in_i.second_link;
      lc_q    <= in_i.third_link;
      dw_q    <= in_i.data_word;
      tgt_q   <= in_i.target_index;
      fsel_q  <= in_i.field_select;
    end
    v_q      <= v_d;
  end

  always_ff @(posedge clk_i) begin
    p_idx_q  <= p_idx_d;
    p_kind_q <= p_kind_d;
    p_a_q    <= p_a_d;
    p_b_q    <= p_b_d;
    p_c_q    <= p_c_d;
    p_pay_q  <= p_pay_d;
    if (ctrl_i.op == OP_FINISH) begin
      out_o.status       <= ctrl_i.status;
      out_o.cell_index   <= ok ? p_idx_q  : '0;
      out_o.cell_kind    <= ok ? p_kind_q : '0;
      out_o.link_a       <= ok ? p_a_q    : '0;
      out_o.link_b       <= ok ? p_b_q    : '0;
      out_o.link_c       <= ok ? p_c_q    : '0;
      out_o.payload      <= ok ? p_pay_q  : '0;
      out_o.freed_count  <= FREED_W'(lf_q);
      out_o.roots_in_use <= ROOTS_W'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_gc_q    <= 1'b0;
      cursor_q    <= '0;
      i_q         <= '0;
      freed_q     <= '0;
      lf_q        <= '0;
      cnt_q       <= '0;
      r_q         <= '0;
      sp_q        <= '0;
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) cfg_gc_q <= cfg_i.data;
      cursor_q    <= cursor_d;
      i_q         <= i_d;
      freed_q     <= freed_d;
      lf_q        <= lf_d;
      cnt_q       <= cnt_d;
      r_q         <= r_d;
      sp_q        <= sp_d;
      over_q      <= over_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

// ===== rtl/msch_ctrl.sv =====
// ---------------------------------------------------------------------------
// Mark-sweep cell heap controller
// Sequences commands, allocation scan, mark, sweep and result delivery.
// ---------------------------------------------------------------------------
module msch_ctrl import msch_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dp_stat_t  stat_i,
  output ctrl_t     ctrl_o
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_READ_WAIT, S_POP_WAIT, S_SCAN, S_SCAN_CHK,
    S_GC_START, S_GC_ROOT, S_GC_ROOT_PUSH, S_GC_POP, S_GC_CHECK, S_GC_MARK,
    S_GC_PUSH_B, S_GC_PUSH_C, S_GC_MARKDONE, S_GC_UNMARK, S_GC_SWEEP_RD,
    S_GC_SWEEP_WR, S_GC_DONE, S_GC_RETURN, S_FINISH
  } state_e;

  state_e            state_q, state_d;
  logic [STAT_W-1:0] fin_q, fin_d, gc_st_q, gc_st_d;
  logic              pre_q, pre_d, second_q, second_d, three_q, three_d;

  always_comb begin
    state_d         = state_q;
    fin_d           = fin_q;
    gc_st_d         = gc_st_q;
    pre_d           = pre_q;
    second_d        = second_q;
    three_d         = three_q;
    ctrl_o.op       = OP_NOP;
    ctrl_o.in_ready = 1'b0;
    ctrl_o.status   = fin_q;
    unique case (state_q)
      S_CLEAR: begin
        ctrl_o.op = OP_CLEAR;
        if (stat_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (stat_i.in_fire) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        fin_d   = ST_OK;
        state_d = S_FINISH;
        unique case (stat_i.cmd)
          CMD_ALLOC: begin
            if (stat_i.ctype_unused) begin
              fin_d = ST_BAD_INDEX;
            end else if (stat_i.cfg_gc) begin
              pre_d = 1'b1; state_d = S_GC_START;
            end else begin
              second_d = 1'b0; state_d = S_SCAN;
            end
          end
          CMD_READ: begin
            if (stat_i.tgt_oob) fin_d = ST_BAD_INDEX;
            else begin
              ctrl_o.op = OP_READ_CELL; state_d = S_READ_WAIT;
            end
          end
          CMD_WRITE: begin
            if (stat_i.tgt_oob) fin_d = ST_BAD_INDEX;
            else ctrl_o.op = OP_WRITE_FIELD;
          end
          CMD_PUSH: begin
            if (stat_i.roots_full) fin_d = ST_ROOTS;
            else ctrl_o.op = OP_PUSH_ROOT;
          end
          CMD_POP: begin
            if (stat_i.roots_empty) fin_d = ST_ROOTS;
            else begin
              ctrl_o.op = OP_POP_ROOT; state_d = S_POP_WAIT;
            end
          end
          CMD_SET: begin
            if (stat_i.set_bad) fin_d = ST_BAD_INDEX;
            else ctrl_o.op = OP_SET_ROOT;
          end
          CMD_COLLECT: begin
            pre_d = 1'b0; state_d = S_GC_START;
          end
          default: ;
        endcase
      end
      S_READ_WAIT: begin
        ctrl_o.op = OP_READ_DONE; state_d = S_FINISH;
      end
      S_POP_WAIT: begin
        ctrl_o.op = OP_POP_DONE; state_d = S_FINISH;
      end
      S_SCAN: begin
        if (stat_i.cursor_end) begin
          if (second_q) begin
            fin_d = ST_OOM; state_d = S_FINISH;
          end else begin
            pre_d = 1'b0; state_d = S_GC_START;
          end
        end else begin
          ctrl_o.op = OP_SCAN_RD; state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (stat_i.tag_free) begin
          ctrl_o.op = OP_ALLOC; fin_d = ST_OK; state_d = S_FINISH;
        end else begin
          ctrl_o.op = OP_SCAN_NEXT; state_d = S_SCAN;
        end
      end
      S_GC_START: begin
        ctrl_o.op = OP_GC_START; state_d = S_GC_ROOT;
      end
      S_GC_ROOT: begin
        if (stat_i.root_done) state_d = S_GC_MARKDONE;
        else begin
          ctrl_o.op = OP_ROOT_RD; state_d = S_GC_ROOT_PUSH;
        end
      end
      S_GC_ROOT_PUSH: begin
        ctrl_o.op = OP_ROOT_PUSH; state_d = S_GC_POP;
      end
      S_GC_POP: begin
        if (stat_i.stack_empty) begin
          ctrl_o.op = OP_ROOT_NEXT; state_d = S_GC_ROOT;
        end else begin
          ctrl_o.op = OP_STK_POP; state_d = S_GC_CHECK;
        end
      end
      S_GC_CHECK: begin
        if (stat_i.v_oob) state_d = S_GC_POP;
        else begin
          ctrl_o.op = OP_CELL_RD; state_d = S_GC_MARK;
        end
      end
      S_GC_MARK: begin
        if (stat_i.skip_cell) state_d = S_GC_POP;
        else begin
          ctrl_o.op = OP_MARK;
          three_d   = stat_i.follow3;
          state_d   = (stat_i.follow2 | stat_i.follow3) ? S_GC_PUSH_B : S_GC_POP;
        end
      end
      S_GC_PUSH_B: begin
        ctrl_o.op = OP_PUSH_B;
        state_d   = three_q ? S_GC_PUSH_C : S_GC_POP;
      end
      S_GC_PUSH_C: begin
        ctrl_o.op = OP_PUSH_C; state_d = S_GC_POP;
      end
      S_GC_MARKDONE: begin
        ctrl_o.op = OP_SWEEP_START;
        state_d   = stat_i.over ? S_GC_UNMARK : S_GC_SWEEP_RD;
      end
      S_GC_UNMARK: begin
        ctrl_o.op = OP_UNMARK;
        if (stat_i.sweep_last) state_d = S_GC_DONE;
      end
      S_GC_SWEEP_RD: begin
        ctrl_o.op = OP_SWEEP_RD; state_d = S_GC_SWEEP_WR;
      end
      S_GC_SWEEP_WR: begin
        ctrl_o.op = OP_SWEEP_WR;
        state_d   = stat_i.sweep_last ? S_GC_DONE : S_GC_SWEEP_RD;
      end
      S_GC_DONE: begin
        ctrl_o.op = OP_GC_DONE;
        priority if (stat_i.over) gc_st_d = ST_OVERFLOW;
        else if (stat_i.freed_zero) gc_st_d = ST_OOM;
        else gc_st_d = ST_OK;
        state_d = S_GC_RETURN;
      end
      S_GC_RETURN: begin
        priority if (stat_i.cmd != CMD_ALLOC || gc_st_q != ST_OK) begin
          fin_d = gc_st_q; state_d = S_FINISH;
        end else if (pre_q) begin
          pre_d = 1'b0; second_d = 1'b0; state_d = S_SCAN;
        end else begin
          second_d = 1'b1; state_d = S_SCAN;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          ctrl_o.op = OP_FINISH; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      fin_q    <= ST_OK;
      gc_st_q  <= ST_OK;
      pre_q    <= 1'b0;
      second_q <= 1'b0;
      three_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      fin_q    <= fin_d;
      gc_st_q  <= gc_st_d;
      pre_q    <= pre_d;
      second_q <= second_d;
      three_q  <= three_d;
    end
  end

endmodule

// ===== rtl/msch_checker.sv =====
// ---------------------------------------------------------------------------
// Mark-sweep cell heap port checker
// Result channel checks, bound to the top level.
// ---------------------------------------------------------------------------
`include "mark_sweep_cell_heap_top_assert.svh"

module msch_checker import msch_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [STAT_W-1:0] status_i,
  input logic [LINK_W-1:0] cell_index_i,
  input logic [DATA_W-1:0] payload_i,
  input logic [FREED_W-1:0] freed_count_i,
  input logic [ROOTS_W-1:0] roots_in_use_i
);

  `MSCH_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i))
  `MSCH_NEVER(a_status_range, out_valid_i && status_i > ST_OVERFLOW)
  `MSCH_ASSERT(a_fail_zero, out_valid_i && status_i != ST_OK |-> cell_index_i == '0 && payload_i == '0)
  `MSCH_NEVER(a_counts_range, out_valid_i && (32'(roots_in_use_i) > ROOT_SLOTS || 32'(freed_count_i) > HEAP_CELLS))

endmodule

bind mark_sweep_cell_heap_top msch_checker u_msch_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .status_i       (out_o.status),
  .cell_index_i   (out_o.cell_index),
  .payload_i      (out_o.payload),
  .freed_count_i  (out_o.freed_count),
  .roots_in_use_i (out_o.roots_in_use)
);
